/* src/md5_pkg.sv */
// Package for the MD5 stream hasher: types, round constants and step helpers.
// Used by md5_front, md5_core and md5_stream_hasher; depends on nothing.
package md5_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } front_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } core_state_e;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      unique case (i)
        6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    begin
      unique case ({i[5:4], i[1:0]})
        4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
        4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
        4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    logic [3:0] n;
    begin
      n = i[3:0];
      unique case (i[5:4])
        2'd0: g = n;
        2'd1: g = 4'((n << 2) + n + 4'd1);
        2'd2: g = 4'((n << 1) + n + 4'd5);
        default: g = 4'((n << 3) - n);
      endcase
      return g;
    end
  endfunction

endpackage

/* src/md5_front.sv */
// Front end: takes input transactions, drops idle items, queues the rest.
// Depends on md5_pkg.
module md5_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           data_byte_i,
  input  logic                 byte_valid_i,
  input  logic                 message_end_i,
  output logic                 q_valid_o,
  output md5_pkg::front_item_t q_item_o,
  input  logic                 q_take_i
);

  md5_pkg::front_item_t mem_q [md5_pkg::QueueDepth];
  logic [md5_pkg::QueueAw:0] wr_q, wr_d, rd_q, rd_d;
  logic wr_en;

  assign full = (wr_q[md5_pkg::QueueAw] != rd_q[md5_pkg::QueueAw]) &&
                (wr_q[md5_pkg::QueueAw-1:0] == rd_q[md5_pkg::QueueAw-1:0]);
  assign wr_en = push && !full && (byte_valid_i || message_end_i);
  assign q_valid_o = (wr_q != rd_q);
  assign q_item_o = mem_q[rd_q[md5_pkg::QueueAw-1:0]];
  assign wr_d = wr_en ? wr_q + 1'b1 : wr_q;
  assign rd_d = (q_take_i && q_valid_o) ? rd_q + 1'b1 : rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q[md5_pkg::QueueAw-1:0]] <= '{data: data_byte_i, valid: byte_valid_i,
                                             last: message_end_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

endmodule

/* src/md5_core.sv */
// Back end: block buffer, one MD5 round per cycle, padding and digest output.
// Depends on md5_pkg.
module md5_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  md5_pkg::front_item_t q_item_i,
  output logic                 q_take_o,
  output logic                 empty,
  input  logic                 pop,
  output logic [31:0]          digest_word_o,
  output logic                 digest_last_o
);

  md5_pkg::core_state_e state_q, state_d;
  logic [31:0] m_q [16];
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;
  logic        fin_q;
  logic        pad2_q;
  logic        padded_q;
  logic [1:0]  emit_q;

  logic [5:0]  idx;
  logic [31:0] f, sum, rot;
  logic [4:0]  sh;
  logic        take_byte, end_item, start_rnd;

  assign idx = bits_q[8:3];
  assign take_byte = (state_q == md5_pkg::ST_IDLE) && q_valid_i;

  always_comb begin
    unique case (rnd_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    sh  = md5_pkg::round_s(rnd_q);
    sum = a_q + f + md5_pkg::round_k(rnd_q) + m_q[md5_pkg::round_g(rnd_q)];
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_comb begin
    end_item  = take_byte && q_item_i.last;
    start_rnd = take_byte && ((q_item_i.valid && idx == 6'd63) || q_item_i.last);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      md5_pkg::ST_IDLE: begin
        if (take_byte && q_item_i.valid && idx == 6'd63) state_d = md5_pkg::ST_ROUND;
        else if (end_item) state_d = md5_pkg::ST_PAD;
      end
      md5_pkg::ST_PAD:   state_d = md5_pkg::ST_ROUND;
      md5_pkg::ST_ROUND: if (rnd_q == 6'd63) state_d = md5_pkg::ST_FOLD;
      md5_pkg::ST_FOLD: begin
        if (!fin_q) state_d = md5_pkg::ST_IDLE;
        else if (!padded_q || pad2_q) state_d = md5_pkg::ST_PAD;
        else state_d = md5_pkg::ST_EMIT;
      end
      md5_pkg::ST_EMIT: if (pop && emit_q == 2'd3) state_d = md5_pkg::ST_IDLE;
      default: state_d = md5_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_take_o = take_byte;
    empty = (state_q != md5_pkg::ST_EMIT);
    digest_word_o = h_q[emit_q];
    digest_last_o = (emit_q == 2'd3);
  end

  always_ff @(posedge clk_i) begin
    if (take_byte && q_item_i.valid) begin
      m_q[idx[5:2]][8*idx[1:0] +: 8] <= q_item_i.data;
    end
    if (state_q == md5_pkg::ST_PAD) begin
      for (int j = 0; j < 64; j++) begin
        if (j >= 56 && (pad2_q || idx < 6'd56)) begin
          m_q[j/4][8*(j%4) +: 8] <= bits_q[8*(j%8) +: 8];
        end else if (!pad2_q && 6'(j) == idx) begin
          m_q[j/4][8*(j%4) +: 8] <= md5_pkg::PadByte;
        end else if (pad2_q || 6'(j) > idx) begin
          m_q[j/4][8*(j%4) +: 8] <= 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= md5_pkg::ST_IDLE;
      h_q[0] <= md5_pkg::InitA;
      h_q[1] <= md5_pkg::InitB;
      h_q[2] <= md5_pkg::InitC;
      h_q[3] <= md5_pkg::InitD;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
      bits_q <= '0;
      rnd_q <= '0;
      fin_q <= 1'b0;
      pad2_q <= 1'b0;
      padded_q <= 1'b0;
      emit_q <= '0;
    end else begin
      state_q <= state_d;
      if (take_byte && q_item_i.valid) bits_q <= bits_q + 64'd8;
      if (end_item) fin_q <= 1'b1;
      if (start_rnd || state_q == md5_pkg::ST_PAD) begin
        a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
        rnd_q <= '0;
      end
      if (state_q == md5_pkg::ST_PAD) padded_q <= 1'b1;
      if (state_q == md5_pkg::ST_PAD && !pad2_q) pad2_q <= (idx >= 6'd56);
      else if (state_q == md5_pkg::ST_PAD) pad2_q <= 1'b0;
      if (state_q == md5_pkg::ST_ROUND) begin
        a_q <= d_q;
        d_q <= c_q;
        c_q <= b_q;
        b_q <= b_q + rot;
        rnd_q <= rnd_q + 6'd1;
      end
      if (state_q == md5_pkg::ST_FOLD) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
      end
      if (state_q == md5_pkg::ST_EMIT && pop) begin
        emit_q <= emit_q + 2'd1;
        if (emit_q == 2'd3) begin
          h_q[0] <= md5_pkg::InitA;
          h_q[1] <= md5_pkg::InitB;
          h_q[2] <= md5_pkg::InitC;
          h_q[3] <= md5_pkg::InitD;
          bits_q <= '0;
          fin_q <= 1'b0;
          padded_q <= 1'b0;
        end
      end
    end
  end

endmodule

/* src/md5_stream_hasher.sv */
// MD5 stream hasher: byte queue front end feeding a one-round-per-cycle core.
// A block's last byte holds the core through its take, the 64 rounds and the fold.
// Message end: padded and hashed as one or two blocks before the first digest word, then one word per pop.
// Throughput ~1 byte/cycle within a block, 4-entry queue absorbs short bursts.
// Reset (rst_ni low, asynchronous) empties the queue and loads the MD5 initial words.
// Depends on md5_pkg, md5_front, md5_core.
module md5_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        message_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o
);

  logic                 q_valid;
  logic                 q_take;
  md5_pkg::front_item_t q_item;

  md5_front u_front (
    .clk_i, .rst_ni, .push, .full, .data_byte_i, .byte_valid_i, .message_end_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_take_i(q_take)
  );

  md5_core u_core (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_take_o(q_take),
    .empty, .pop, .digest_word_o, .digest_last_o
  );

endmodule

/* src/md5_checker.sv */
// Port-level checker for the MD5 stream hasher, bound to the top level.
// Depends only on the top-level ports.
module md5_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] digest_word_o,
  input logic        digest_last_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(digest_word_o) && $stable(digest_last_o)))
    else $error("held result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !digest_last_o) |=> !empty)
    else $error("digest words not contiguous");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && digest_last_o) |=> empty)
    else $error("result after last word");

  assert property (@(posedge clk_i) !rst_ni |=> (!full && empty))
    else $error("reset state wrong");

endmodule

bind md5_stream_hasher md5_checker u_md5_checker (
  .clk_i, .rst_ni, .full, .empty, .pop, .digest_word_o, .digest_last_o
);

/* tb/sv/testbench.sv */
// Testbench for md5_stream_hasher: byte-serial MD5 checked against an in-bench predictor.
// Drives byte transactions through the push/full port, checks digest words from empty/pop.
// Depends on md5_stream_hasher and its package md5_pkg.
module testbench;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = '0;
  logic        byte_valid_i = 1'b0;
  logic        message_end_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] digest_word_o;
  logic        digest_last_o;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_item_t;

  logic [31:0]  hash_state [4];
  logic [7:0]   msg_block [64];
  logic [63:0]  msg_bits;
  digest_item_t digest_queue [$];
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  localparam logic [31:0] KTable [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int RotTable [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  md5_stream_hasher dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void load_iv();
    hash_state[0] = md5_pkg::InitA;
    hash_state[1] = md5_pkg::InitB;
    hash_state[2] = md5_pkg::InitC;
    hash_state[3] = md5_pkg::InitD;
    msg_bits = '0;
  endfunction

  function automatic void compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t, sum;
    int g, ph, s;
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    for (int i = 0; i < 16; i++)
      m[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
    for (int i = 0; i < 64; i++) begin
      ph = i / 16;
      case (ph)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5*i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
      endcase
      s = RotTable[ph*4 + i%4];
      sum = a + f + KTable[i] + m[g];
      t = d; d = c; c = b;
      b = b + ((sum << s) | (sum >> (32 - s)));
      a = t;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
  endfunction

  function automatic void predict_digest(logic [7:0] bval, logic vld, logic fin);
    int idx;
    if (vld) begin
      idx = int'(msg_bits[8:3]);
      msg_block[idx] = bval;
      msg_bits += 64'd8;
      if (idx == 63) compress();
    end
    if (fin) begin
      idx = int'(msg_bits[8:3]);
      msg_block[idx] = md5_pkg::PadByte;
      idx++;
      if (idx > 56) begin
        for (int k = idx; k < 64; k++) msg_block[k] = '0;
        compress();
        idx = 0;
      end
      for (int k = idx; k < 56; k++) msg_block[k] = '0;
      for (int k = 0; k < 8; k++) msg_block[56+k] = msg_bits[8*k +: 8];
      compress();
      for (int k = 0; k < 4; k++) digest_queue.push_back('{hash_state[k], k == 3});
      load_iv();
    end
  endfunction

  task automatic send_byte(logic [7:0] bval, logic vld, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= bval;
    byte_valid_i <= vld;
    message_end_i <= fin;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_digest(bval, vld, fin);
  endtask

  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest word %h last %b", $time, digest_word_o, digest_last_o);
        mismatches++;
      end else begin
        if (digest_word_o !== digest_queue[0].word || digest_last_o !== digest_queue[0].last) begin
          $display("%0t: expected %h last %b, actual %h last %b", $time,
                   digest_queue[0].word, digest_queue[0].last, digest_word_o, digest_last_o);
          mismatches++;
        end
        void'(digest_queue.pop_front());
      end
    end
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_message(int len, int nul_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < nul_pct) send_byte(8'($urandom), 1'b0, 1'b0);
      send_byte(8'($urandom), 1'b1, 1'b0);
    end
    if ($urandom_range(1)) send_byte(8'($urandom), 1'b1, 1'b1);
    else send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h61, 1'b1, 1'b1);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h5a, 1'b0, 1'b0);
    send_byte(8'ha5, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_boundaries();
    int   lens [3] = '{55, 55, 63};
    logic with_byte [3] = '{1'b0, 1'b1, 1'b1};
    foreach (lens[i]) begin
      for (int k = 0; k < lens[i]; k++) send_byte(8'($urandom), 1'b1, 1'b0);
      send_byte(8'($urandom), with_byte[i], 1'b1);
    end
  endtask

  task automatic test_random(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
      send_message(len, 10);
      sent += len + 1;
    end
  endtask

  initial begin
    load_iv();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_boundaries();
    wait_drained();
    send_idle_pct = 14; recv_idle_pct = 52;
    test_random(30);
    wait_drained();
    send_idle_pct = 52; recv_idle_pct = 14;
    test_random(30);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(30);
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && digest_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
